// File: rtl/pip_pkg.sv
// Shared types, constants and codes for the point-in-polygon test unit.
package pip_pkg;

  // Default sizing, handed to the top level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 32;

  // Fixed field widths of the words on the ports
  localparam int FIELD_WIDTH    = 32;
  localparam int SLOT_WIDTH     = 4;
  localparam int COUNT_WIDTH    = 5;
  localparam int VCNT_WIDTH     = 5;
  localparam int EPS_WIDTH      = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 1;

  // Register indexes on the config port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HORIZ_EPS    = 1'd1;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Input word
  typedef struct packed {
    logic                          req_type;
    logic [SLOT_WIDTH-1:0]         vertex_slot;
    logic signed [FIELD_WIDTH-1:0] point_x;
    logic signed [FIELD_WIDTH-1:0] point_y;
  } req_t;

  // Result word
  typedef struct packed {
    logic                   inside_res;
    logic [COUNT_WIDTH-1:0] crossing_count;
  } res_t;

  // Step controls from the sequencer to the edge unit
  typedef struct packed {
    logic clr;
    logic load_a;
    logic diff;
    logic mag;
    logic mul_lhs;
    logic mul_rhs;
    logic cmp;
  } edge_ctl_t;

endpackage

// File: rtl/pip_vertex_ram.sv
// Vertex store: one write port, one registered read port.
module pip_vertex_ram import pip_pkg::*; #(
  parameter int DEPTH  = MAX_VERTICES_DEF,
  parameter int DATA_W = 2 * COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pip_edge_unit.sv
// Edge datapath: differences, magnitudes, one shared multiplier, crossing compare and count.
module pip_edge_unit import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  edge_ctl_t                              ctl,
  input  logic [COORD_WIDTH-1:0]                 px,
  input  logic [COORD_WIDTH-1:0]                 py,
  input  logic [EPS_WIDTH-1:0]                   eps,
  input  logic [2*COORD_WIDTH-1:0]               b_vtx,
  output logic [$clog2(MAX_VERTICES+1)-1:0]      cnt
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_VERTICES+1);

  logic [CW-1:0] bx, by;
  logic [CW-1:0] ax, ay;
  // differences, one bit wider than a coordinate
  logic [CW:0]   dx, dy, t, t2, u;
  logic [CW-1:0] mag_t, mag_dx, mag_u, mag_dy;
  logic          dx_neg, u_neg, skip;
  logic [2*CW-1:0] lhs, rhs, prod;
  logic [CW-1:0]   mul_a, mul_b;

  // magnitude step results
  logic [CW:0]   abs_t, abs_dx, abs_u, abs_dy;
  logic          in_span, too_flat, rises;

  // compare step
  logic          na, nb, gt;

  assign bx = b_vtx[2*CW-1:CW];
  assign by = b_vtx[CW-1:0];

  // absolute values and edge filters
  always_comb begin
    abs_t  = t[CW]  ? (~t  + (CW+1)'(1)) : t;
    abs_dx = dx[CW] ? (~dx + (CW+1)'(1)) : dx;
    abs_u  = u[CW]  ? (~u  + (CW+1)'(1)) : u;
    abs_dy = dy[CW] ? (~dy + (CW+1)'(1)) : dy;
    rises  = !dy[CW] && (dy != '0);
    // y1 <= py < y2 when rising, y2 <= py < y1 otherwise; flat edges fail both
    in_span  = rises ? (!t[CW] && t2[CW]) : (!t2[CW] && t[CW]);
    too_flat = {{EPS_WIDTH{1'b0}}, abs_dy[CW-1:0]} < {{CW{1'b0}}, eps};
  end

  // shared multiplier
  assign mul_a = ctl.mul_rhs ? mag_u  : mag_t;
  assign mul_b = ctl.mul_rhs ? mag_dy : mag_dx;
  assign prod  = (2*CW)'(mul_a) * (2*CW)'(mul_b);

  // signed compare of sgn(dx)*lhs against sgn(u)*rhs
  always_comb begin
    na = dx_neg && (lhs != '0);
    nb = u_neg  && (rhs != '0);
    if (na != nb) begin
      gt = nb;
    end else if (!na) begin
      gt = lhs > rhs;
    end else begin
      gt = lhs < rhs;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      ax <= bx;
      ay <= by;
    end
    if (ctl.diff) begin
      dx <= {bx[CW-1], bx} - {ax[CW-1], ax};
      dy <= {by[CW-1], by} - {ay[CW-1], ay};
      t  <= {py[CW-1], py} - {ay[CW-1], ay};
      t2 <= {py[CW-1], py} - {by[CW-1], by};
      u  <= {px[CW-1], px} - {ax[CW-1], ax};
      ax <= bx;
      ay <= by;
    end
    if (ctl.mag) begin
      mag_t  <= abs_t[CW-1:0];
      mag_dx <= abs_dx[CW-1:0];
      mag_u  <= abs_u[CW-1:0];
      mag_dy <= abs_dy[CW-1:0];
      dx_neg <= dx[CW];
      u_neg  <= u[CW];
      skip   <= too_flat || !in_span;
    end
    if (ctl.mul_lhs) begin
      lhs <= prod;
    end
    if (ctl.mul_rhs) begin
      rhs <= prod;
    end
  end

  // crossing counter
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      cnt <= '0;
    end else if (ctl.cmp && !skip && gt) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

// File: rtl/point_in_polygon_test_unit.sv
// Top level of the ray-casting point-in-polygon test unit: config, sequencer, store and datapath.
//
//   channel  | handshake               | word
//   ---------+-------------------------+---------------------------------------
//   request  | start, busy             | req (req_t): load vertex or query
//   result   | done (one-cycle strobe) | res (res_t): inside flag, crossings
//   config   | cfg_we                  | cfg_index, cfg_data
//
// A load leaves busy low; a query keeps busy high until its result strobe, which
// falls in the last busy cycle. Each edge takes five steps: difference,
// magnitude, two passes through the single shared multiplier, and the compare.
// With no vertices a query goes straight to the strobe and counts nothing.
// Reset clears the sequencer and config registers; the vertex store is not
// cleared. The receiver cannot stall: a result is shown for one cycle only.
module point_in_polygon_test_unit import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  req_t                      req,
  output logic                      done,
  output res_t                      res,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES+1);
  localparam int CNT_W = $clog2(MAX_VERTICES+1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WAIT = 4'd1;
  localparam logic [3:0] S_VA   = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_MAG  = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]            state;
  logic [VCNT_WIDTH-1:0] vertex_count;
  logic [EPS_WIDTH-1:0]  horizontal_epsilon;
  logic [CW-1:0]         px, py;
  logic [IW-1:0]         rd_ptr, edge_idx;
  logic [NW-1:0]         n_active;
  logic                  accept, acc_query, acc_load, slot_ok;
  logic                  ram_we;
  logic [2*CW-1:0]       ram_rdata;
  logic [CNT_W-1:0]      cnt;
  edge_ctl_t             ctl;

  // index after p on the closed edge list
  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] p, input logic [NW-1:0] n);
    logic [NW-1:0] p1;
    p1 = NW'(p) + NW'(1);
    return (p1 == n) ? '0 : IW'(p1);
  endfunction

  function automatic logic is_last(input logic [IW-1:0] p, input logic [NW-1:0] n);
    return (NW'(p) + NW'(1)) == n;
  endfunction

  assign n_active  = (int'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                         : NW'(vertex_count);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign acc_query = accept && (req.req_type == REQ_QUERY);
  assign acc_load  = accept && (req.req_type == REQ_LOAD);
  assign slot_ok   = int'(req.vertex_slot) < MAX_VERTICES;
  assign ram_we    = acc_load && slot_ok;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count       <= '0;
      horizontal_epsilon <= EPS_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count       <= cfg_data[VCNT_WIDTH-1:0];
        REG_HORIZ_EPS:    horizontal_epsilon <= cfg_data[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // test point latch
  always_ff @(posedge clk) begin
    if (acc_query) begin
      px <= req.point_x[CW-1:0];
      py <= req.point_y[CW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_ptr   <= '0;
      edge_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc_query) begin
            rd_ptr   <= '0;
            edge_idx <= '0;
            state    <= (n_active == '0) ? S_DONE : S_WAIT;
          end
        end
        S_WAIT: begin
          rd_ptr <= wrap_next(rd_ptr, n_active);
          state  <= S_VA;
        end
        S_VA: state <= S_DIFF;
        S_DIFF: begin
          // fetch the far end of the following edge
          rd_ptr <= wrap_next(rd_ptr, n_active);
          state  <= S_MAG;
        end
        S_MAG:  state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_CMP;
        S_CMP: begin
          if (is_last(edge_idx, n_active)) begin
            state <= S_DONE;
          end else begin
            edge_idx <= edge_idx + IW'(1);
            state    <= S_DIFF;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // step decode for the edge unit
  always_comb begin
    ctl.clr     = acc_query;
    ctl.load_a  = (state == S_VA);
    ctl.diff    = (state == S_DIFF);
    ctl.mag     = (state == S_MAG);
    ctl.mul_lhs = (state == S_MUL1);
    ctl.mul_rhs = (state == S_MUL2);
    ctl.cmp     = (state == S_CMP);
  end

  pip_vertex_ram #(
    .DEPTH  (MAX_VERTICES),
    .DATA_W (2 * CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(req.vertex_slot)),
    .wdata ({req.point_x[CW-1:0], req.point_y[CW-1:0]}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  pip_edge_unit #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .px    (px),
    .py    (py),
    .eps   (horizontal_epsilon),
    .b_vtx (ram_rdata),
    .cnt   (cnt)
  );

  // result word
  assign done               = (state == S_DONE);
  assign res.inside_res     = cnt[0];
  assign res.crossing_count = COUNT_WIDTH'(cnt);

endmodule

// File: rtl/pip_checker.sv
// Port-level checks for the point-in-polygon test unit, bound to the top level.
module pip_checker import pip_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input res_t res
);

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  // a load never makes the unit busy
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_LOAD) |=> !busy)
    else $error("load left the unit busy");

  // a query occupies the unit until its result
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // result appears only while the query still holds the unit
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a query");

  // inside flag is the parity of the crossing count
  a_parity: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.inside_res == res.crossing_count[0]))
    else $error("inside flag disagrees with crossing parity");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .res   (res)
);

// File: tb/sv/tb.sv
// Testbench for the point-in-polygon test unit: directed table, random phases, queued result check.
`timescale 1ns / 1ps

module tb;
  import pip_pkg::*;

  localparam int TOTAL_ITEMS = 1950;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_QUERY
  } row_kind_t;

  // One row of the directed table
  typedef struct {
    row_kind_t                 kind;
    logic [CFG_IDX_WIDTH-1:0]  reg_idx;
    logic [CFG_DATA_WIDTH-1:0] reg_val;
    req_t                      word;
    bit                        typed;
    res_t                      want;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  req_t                      req;
  logic                      done;
  res_t                      res;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  // Shadow copy of the polygon and the registers
  logic signed [31:0]   poly_x [MAX_VERTICES_DEF];
  logic signed [31:0]   poly_y [MAX_VERTICES_DEF];
  logic [VCNT_WIDTH-1:0] poly_count;
  logic [EPS_WIDTH-1:0]  poly_eps;

  res_t     pending_res_q [$];
  dir_row_t dir_rows [$];
  res_t     got_want;
  int       errors = 0;
  int       items_sent = 0;

  point_in_polygon_test_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Crossings strictly right of the point, exact cross-multiplied compare
  function automatic logic [COUNT_WIDTH-1:0] count_crossings(logic signed [31:0] px,
                                                             logic signed [31:0] py);
    logic signed [67:0] x1, y1, x2, y2, dy, ady, lo, hi, t, dx, u, qx, qy, eps_w;
    int n, j;
    logic [COUNT_WIDTH-1:0] hits;
    hits = '0;
    n = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
    qx = 68'(px);
    qy = 68'(py);
    eps_w = {52'd0, poly_eps};
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      x1 = 68'(poly_x[i]);
      y1 = 68'(poly_y[i]);
      x2 = 68'(poly_x[j]);
      y2 = 68'(poly_y[j]);
      dy = y2 - y1;
      ady = (dy < 0) ? -dy : dy;
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      // skip near-horizontal edges and edges whose span misses the point
      if (ady >= eps_w && qy >= lo && qy < hi) begin
        t = qy - y1;
        if (t < 0) t = -t;
        dx = x2 - x1;
        u = qx - x1;
        if (t * dx > u * ady) hits++;
      end
    end
    return hits;
  endfunction

  function automatic logic signed [31:0] rand_coord(int scale);
    logic signed [31:0] v;
    int lim;
    lim = (scale == 0) ? 16 : (scale == 1) ? 4096 : (1 << 24);
    if (scale >= 3) begin
      if ($urandom_range(7) == 0) v = $urandom_range(1) ? C_MAX : C_MIN;
      else v = $urandom;
    end else begin
      v = $urandom_range(2 * lim);
      v = v - lim;
    end
    return v;
  endfunction

  // Test point: random, on a vertex row, on a vertex, on an edge midpoint, or full-range
  function automatic req_t random_query(int scale, int n_use);
    req_t w;
    int i, j, pick;
    logic signed [32:0] sx, sy;
    i = (n_use > 0) ? $urandom_range(n_use - 1) : $urandom_range(MAX_VERTICES_DEF - 1);
    j = (n_use > 0 && i + 1 < n_use) ? i + 1 : 0;
    pick = $urandom_range(99);
    w.req_type = REQ_QUERY;
    w.vertex_slot = SLOT_WIDTH'($urandom);
    w.point_x = rand_coord(scale);
    w.point_y = rand_coord(scale);
    if (pick >= 35 && pick < 60) begin
      w.point_y = poly_y[i];
    end else if (pick >= 60 && pick < 75) begin
      w.point_x = poly_x[i];
      w.point_y = poly_y[i];
    end else if (pick >= 75 && pick < 90) begin
      sx = 33'(poly_x[i]) + 33'(poly_x[j]);
      sy = 33'(poly_y[i]) + 33'(poly_y[j]);
      w.point_x = sx[32:1];
      w.point_y = sy[32:1];
    end else if (pick >= 90) begin
      w.point_x = rand_coord(3);
      w.point_y = rand_coord(3);
    end
    return w;
  endfunction

  function automatic req_t vertex_word(logic [SLOT_WIDTH-1:0] slot,
                                       logic signed [31:0] x, logic signed [31:0] y);
    req_t w;
    w.req_type = REQ_LOAD;
    w.vertex_slot = slot;
    w.point_x = x;
    w.point_y = y;
    return w;
  endfunction

  function automatic void dir_cfg(logic [CFG_IDX_WIDTH-1:0] idx,
                                  logic [CFG_DATA_WIDTH-1:0] val);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.word = '0;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_load(logic [SLOT_WIDTH-1:0] slot,
                                   logic signed [31:0] x, logic signed [31:0] y);
    dir_row_t r;
    r.kind = ROW_LOAD;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.word = vertex_word(slot, x, y);
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_query(logic signed [31:0] x, logic signed [31:0] y,
                                    bit typed, res_t want);
    dir_row_t r;
    r.kind = ROW_QUERY;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.word.req_type = REQ_QUERY;
    r.word.vertex_slot = '1;
    r.word.point_x = x;
    r.word.point_y = y;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  // Drain: no start, nothing outstanding, then a short pause
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_res_q.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VERTEX_COUNT) poly_count = val[VCNT_WIDTH-1:0];
    else poly_eps = val[EPS_WIDTH-1:0];
  endtask

  // Present one word, wait for acceptance, update shadow state or expectations
  task automatic send_item(req_t word, bit typed, res_t typed_res);
    res_t want;
    logic [COUNT_WIDTH-1:0] cnt;
    if (!(items_sent >= 700 && items_sent < 1000)) begin
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    req <= word;
    do @(posedge clk); while (busy);
    items_sent++;
    if (word.req_type == REQ_LOAD) begin
      poly_x[word.vertex_slot] = word.point_x;
      poly_y[word.vertex_slot] = word.point_y;
    end else begin
      if (typed) begin
        want = typed_res;
      end else begin
        cnt = count_crossings(word.point_x, word.point_y);
        want.inside_res = cnt[0];
        want.crossing_count = cnt;
      end
      pending_res_q.push_back(want);
    end
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_res_q.size() == 0) begin
        $error("unexpected result: inside_res=%0d crossing_count=%0d",
               res.inside_res, res.crossing_count);
        errors++;
      end else begin
        got_want = pending_res_q.pop_front();
        if (res.inside_res !== got_want.inside_res) begin
          $error("inside_res: expected %0d, got %0d", got_want.inside_res, res.inside_res);
          errors++;
        end
        if (res.crossing_count !== got_want.crossing_count) begin
          $error("crossing_count: expected %0d, got %0d",
                 got_want.crossing_count, res.crossing_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int scale, n_use, batch, pick, drain;
    logic [VCNT_WIDTH-1:0] vc;
    logic [CFG_DATA_WIDTH-1:0] val;
    res_t none;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    poly_count = '0;
    poly_eps = EPS_WIDTH'(1);
    for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
    end

    // Directed table: empty polygon after reset, a square, extremes, degenerate
    dir_query(32'sd0, 32'sd0, 1'b1, none);
    dir_load(4'd0, -32'sd100, -32'sd100);
    dir_load(4'd1,  32'sd100, -32'sd100);
    dir_load(4'd2,  32'sd100,  32'sd100);
    dir_load(4'd3, -32'sd100,  32'sd100);
    dir_cfg(REG_VERTEX_COUNT, 16'd4);
    dir_query(32'sd0, 32'sd0, 1'b0, none);
    dir_query(32'sd100, 32'sd0, 1'b0, none);    // exactly on the right edge
    dir_query(32'sd0, -32'sd100, 1'b0, none);   // bottom of the y span, included
    dir_query(32'sd0, 32'sd100, 1'b0, none);    // top of the y span, excluded
    dir_cfg(REG_HORIZ_EPS, 16'hFFFF);
    dir_query(32'sd0, 32'sd0, 1'b1, none);      // every edge too flat
    dir_cfg(REG_HORIZ_EPS, 16'd0);
    dir_query(32'sd0, 32'sd0, 1'b0, none);
    dir_load(4'd4, C_MIN, C_MIN);
    dir_load(4'd5, C_MAX, C_MIN);
    dir_load(4'd6, C_MAX, C_MAX);
    dir_load(4'd7, C_MIN, C_MAX);
    dir_load(4'd8, 32'sd0, C_MAX);
    dir_load(4'd9, C_MIN, 32'sd0);
    dir_load(4'd10, C_MAX, -32'sd1);
    dir_load(4'd11, -32'sd1, C_MIN);
    dir_load(4'd12, C_MIN, -32'sd1);
    dir_load(4'd13, C_MAX, 32'sd1);
    dir_load(4'd14, 32'sd0, 32'sd0);
    dir_load(4'd15, C_MIN, C_MAX);
    dir_cfg(REG_VERTEX_COUNT, 16'd31);          // saturates to the full store
    dir_query(C_MIN, 32'sd0, 1'b0, none);
    dir_query(C_MAX, -32'sd1, 1'b0, none);
    dir_cfg(REG_VERTEX_COUNT, 16'd1);
    dir_query(32'sd0, 32'sd0, 1'b1, none);      // single vertex, never inside

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      else send_item(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases: new settings, usually a fresh polygon, then mostly queries
    while (items_sent < TOTAL_ITEMS) begin
      scale = $urandom_range(3);
      pick = $urandom_range(99);
      if (pick < 8) vc = '0;
      else if (pick < 16) vc = VCNT_WIDTH'(1);
      else if (pick < 26) vc = VCNT_WIDTH'($urandom_range(17, 31));
      else if (pick < 50) vc = VCNT_WIDTH'(16);
      else vc = VCNT_WIDTH'($urandom_range(2, 15));
      val = {$urandom_range(99) < 30 ? 11'($urandom) : 11'd0, vc};
      write_reg(REG_VERTEX_COUNT, val);
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(99);
        if (pick < 20) val = '0;
        else if (pick < 40) val = CFG_DATA_WIDTH'(1);
        else if (pick < 50) val = 16'hFFFF;
        else if (scale == 0) val = CFG_DATA_WIDTH'($urandom_range(8));
        else if (scale == 1) val = CFG_DATA_WIDTH'($urandom_range(512));
        else val = CFG_DATA_WIDTH'($urandom_range(65535));
        write_reg(REG_HORIZ_EPS, val);
      end
      n_use = (vc > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vc);
      if ($urandom_range(99) < 80) begin
        for (int s = 0; s < n_use; s++)
          send_item(vertex_word(SLOT_WIDTH'(s), rand_coord(scale), rand_coord(scale)),
                    1'b0, none);
      end
      batch = $urandom_range(6, 30);
      repeat (batch) begin
        if ($urandom_range(99) < 80)
          send_item(random_query(scale, n_use), 1'b0, none);
        else
          send_item(vertex_word(SLOT_WIDTH'($urandom), rand_coord(scale), rand_coord(scale)),
                    1'b0, none);
      end
    end

    // Drain and finish
    start <= 1'b0;
    drain = 0;
    while (pending_res_q.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (90) @(posedge clk);
    if (pending_res_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_res_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pip_pkg.sv
rtl/pip_vertex_ram.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test_unit.sv
rtl/pip_checker.sv
tb/sv/tb.sv
